FILE: rtl/famc_pkg.sv
// ----------------------------------------------------------------------------
// Affine compose package
// Shared widths, types and codes for the fixed point affine compose unit.
// ----------------------------------------------------------------------------
package famc_pkg;

  localparam int unsigned FracBits = 12;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned OffW     = 32;
  localparam int unsigned NumRows  = 3;
  localparam int unsigned NumCols  = 3;
  localparam int unsigned RowIdxW  = 2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [OffW-1:0]  word_t;
  typedef elem_t [NumCols-1:0]     row_vec_t;
  typedef word_t [NumCols-1:0]     col_vec_t;
  typedef logic [RowIdxW-1:0]      row_idx_t;

  // Operation codes of an input word.
  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;

  // Translation mode codes.
  localparam logic ModeCompose = 1'b0;
  localparam logic ModePass    = 1'b1;

  localparam row_idx_t FirstRow = 2'd0;
  localparam row_idx_t LastRow  = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StSum,
    StEmit
  } state_e;

  // Control from the sequencer to the merge stage.
  typedef struct packed {
    logic     load;
    row_idx_t row;
    logic     mode;
  } merge_ctrl_t;

endpackage

FILE: rtl/famc_store.sv
// ----------------------------------------------------------------------------
// Affine compose row store
// Holds the rotation rows and translation terms of both matrices.
// ----------------------------------------------------------------------------
module famc_store (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic                operation_i,
  input  famc_pkg::row_idx_t  row_i,
  input  famc_pkg::row_vec_t  row_data_i,
  input  famc_pkg::word_t     shift_term_i,
  output famc_pkg::row_vec_t  first_rot_o  [famc_pkg::NumRows],
  output famc_pkg::word_t     first_off_o  [famc_pkg::NumRows],
  output famc_pkg::row_vec_t  second_rot_o [famc_pkg::NumRows],
  output famc_pkg::word_t     second_off_o [famc_pkg::NumRows]
);
  import famc_pkg::*;

  row_vec_t first_rot_q  [NumRows];
  word_t    first_off_q  [NumRows];
  row_vec_t second_rot_q [NumRows];
  word_t    second_off_q [NumRows];

  // A row index of three is not a row and leaves the store untouched.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (row_i <= LastRow)) begin
      if (operation_i == OpSecond) begin
        second_rot_q[row_i] <= row_data_i;
        second_off_q[row_i] <= shift_term_i;
      end else begin
        first_rot_q[row_i] <= row_data_i;
        first_off_q[row_i] <= shift_term_i;
      end
    end
  end

  assign first_rot_o  = first_rot_q;
  assign first_off_o  = first_off_q;
  assign second_rot_o = second_rot_q;
  assign second_off_o = second_off_q;

endmodule

FILE: rtl/famc_lane.sv
// ----------------------------------------------------------------------------
// Affine compose dot product lane
// Three-term wrapping dot product with an arithmetic fraction shift.
// ----------------------------------------------------------------------------
module famc_lane (
  input  logic                clk_i,
  input  famc_pkg::row_vec_t  a_i,
  input  famc_pkg::col_vec_t  b_i,
  output famc_pkg::word_t     sum_o
);
  import famc_pkg::*;

  word_t prod_d [NumCols];
  word_t prod_q [NumCols];
  word_t sum_d;
  word_t sum_q;

  // Products keep only their low word, as the arithmetic wraps at 32 bits.
  always_comb begin
    logic signed [ElemW+OffW-1:0] full;
    for (int k = 0; k < NumCols; k++) begin
      full      = a_i[k] * b_i[k];
      prod_d[k] = full[OffW-1:0];
    end
  end

  always_comb begin
    word_t acc;
    acc   = prod_q[0] + prod_q[1] + prod_q[2];
    sum_d = acc >>> FracBits;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/famc_merge.sv
// ----------------------------------------------------------------------------
// Affine compose merge stage
// Joins the lane results into one result row and holds it for the consumer.
// ----------------------------------------------------------------------------
module famc_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  famc_pkg::merge_ctrl_t  ctrl_i,
  input  famc_pkg::col_vec_t     rot_sum_i,
  input  famc_pkg::word_t        off_sum_i,
  input  famc_pkg::word_t        first_off_i,
  input  famc_pkg::word_t        second_off_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output famc_pkg::row_idx_t     out_row_o,
  output famc_pkg::elem_t        out_a_o,
  output famc_pkg::elem_t        out_b_o,
  output famc_pkg::elem_t        out_c_o,
  output famc_pkg::word_t        out_shift_o,
  output logic                   last_o
);
  import famc_pkg::*;

  logic     valid_q;
  row_idx_t row_q;
  elem_t    a_q, b_q, c_q;
  word_t    shift_d, shift_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    if (ctrl_i.mode == ModeCompose) begin
      shift_d = first_off_i + off_sum_i;
    end else begin
      shift_d = second_off_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      row_q   <= ctrl_i.row;
      a_q     <= rot_sum_i[0][ElemW-1:0];
      b_q     <= rot_sum_i[1][ElemW-1:0];
      c_q     <= rot_sum_i[2][ElemW-1:0];
      shift_q <= shift_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign out_a_o     = a_q;
  assign out_b_o     = b_q;
  assign out_c_o     = c_q;
  assign out_shift_o = shift_q;
  assign last_o      = (row_q == LastRow);

endmodule

FILE: rtl/fixed_point_affine_matrix_compose_unit.sv
// ----------------------------------------------------------------------------
// Fixed point affine matrix compose unit
// Composes two 4.12 affine transforms loaded row by row and streams the
// three rows of the composed transform.
// ----------------------------------------------------------------------------
// Each input word loads one row of the first or the second matrix: three
// signed 4.12 rotation elements and a 32-bit translation term. A load that is
// not row 2 of the second matrix leaves the input open, and the next word can
// be taken in the following cycle. Loading row 2 of the second matrix starts
// the compose: the unit stalls its input and produces three result words,
// rows 0, 1 and 2, the last one flagged by last_o. Each result row passes the
// lane product and sum registers and then the merge output register; the input
// stays stalled until the last row is loaded, longer while the consumer stalls.
// Four identical lanes work on a row at once: three produce the rotation
// columns and the fourth the rotated second translation; the merge stage
// truncates the rotation results to 16 bits and adds the first translation,
// or in pass mode substitutes the second matrix translation unchanged. All
// arithmetic wraps at 32 bits and the fraction is removed by an arithmetic
// right shift. Rows that were never loaded hold unknown data after reset, so
// both matrices must be fully loaded before the first compose. The translation
// mode register is to be written through the configuration channel only while
// the unit is idle; the block does not enforce this; the channel is always ready.
// ----------------------------------------------------------------------------
module fixed_point_affine_matrix_compose_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  famc_pkg::row_idx_t  row_i,
  input  famc_pkg::elem_t     elem_a_i,
  input  famc_pkg::elem_t     elem_b_i,
  input  famc_pkg::elem_t     elem_c_i,
  input  famc_pkg::word_t     shift_term_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output famc_pkg::row_idx_t  out_row_o,
  output famc_pkg::elem_t     out_a_o,
  output famc_pkg::elem_t     out_b_o,
  output famc_pkg::elem_t     out_c_o,
  output famc_pkg::word_t     out_shift_o,
  output logic                last_o
);
  import famc_pkg::*;

  state_e      state_q, state_d;
  row_idx_t    row_q, row_d;
  logic        mode_q;
  logic        in_accept;
  logic        trigger;
  logic        merge_ready;
  merge_ctrl_t merge_ctrl;

  row_vec_t    first_rot  [NumRows];
  word_t       first_off  [NumRows];
  row_vec_t    second_rot [NumRows];
  word_t       second_off [NumRows];

  row_vec_t    row_data;
  col_vec_t    lane_cols  [NumCols];
  col_vec_t    rot_sum;
  word_t       off_sum;

  // The configuration register can be written at any time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCompose;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Input words are only taken while no compose is in flight, so the store
  // stays stable for all three result rows.
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign trigger    = in_accept && (operation_i == OpSecond) && (row_i == LastRow);

  assign row_data = {elem_c_i, elem_b_i, elem_a_i};

  famc_store u_store (
    .clk_i        (clk_i),
    .wr_en_i      (in_accept),
    .operation_i  (operation_i),
    .row_i        (row_i),
    .row_data_i   (row_data),
    .shift_term_i (shift_term_i),
    .first_rot_o  (first_rot),
    .first_off_o  (first_off),
    .second_rot_o (second_rot),
    .second_off_o (second_off)
  );

  // Lane c takes column c of the second rotation, sign extended to a word so
  // that every lane is the same unit. The translation lane takes the second
  // translation vector.
  for (genvar c = 0; c < NumCols; c++) begin : g_rot_lane
    always_comb begin
      for (int k = 0; k < NumRows; k++) begin
        lane_cols[c][k] = word_t'(second_rot[k][c]);
      end
    end

    famc_lane u_lane (
      .clk_i (clk_i),
      .a_i   (first_rot[row_q]),
      .b_i   (lane_cols[c]),
      .sum_o (rot_sum[c])
    );
  end

  famc_lane u_off_lane (
    .clk_i (clk_i),
    .a_i   (first_rot[row_q]),
    .b_i   ({second_off[2], second_off[1], second_off[0]}),
    .sum_o (off_sum)
  );

  // Sequencer: one result row passes products, sums and then the output
  // register before the row counter moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= FirstRow;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    row_d           = row_q;
    merge_ctrl.load = 1'b0;
    merge_ctrl.row  = row_q;
    merge_ctrl.mode = mode_q;
    unique case (state_q)
      StIdle: begin
        if (trigger) begin
          state_d = StMul;
          row_d   = FirstRow;
        end
      end
      StMul: begin
        state_d = StSum;
      end
      StSum: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (merge_ready) begin
          merge_ctrl.load = 1'b1;
          if (row_q == LastRow) begin
            state_d = StIdle;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = StMul;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  famc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (merge_ctrl),
    .rot_sum_i    (rot_sum),
    .off_sum_i    (off_sum),
    .first_off_i  (first_off[row_q]),
    .second_off_i (second_off[row_q]),
    .ready_o      (merge_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_a_o      (out_a_o),
    .out_b_o      (out_b_o),
    .out_c_o      (out_c_o),
    .out_shift_o  (out_shift_o),
    .last_o       (last_o)
  );

  // A compose start holds off the next input word.
  a_trigger_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trigger |=> in_stall_o)
    else $error("compose start did not stall the input");

  // A new result row only appears out of the emit step.
  a_emit_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StEmit))
    else $error("result word appeared outside the emit step");

  // While input words are taken, only the final row may still wait.
  a_idle_holds_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_o) |-> last_o)
    else $error("input taken while a non-final row is pending");

  // Rows leave in order: after a non-final row the next one follows it.
  a_row_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (merge_ctrl.load && (row_q != FirstRow)) |-> (out_row_o == row_q - 1'b1))
    else $error("result rows out of order");

endmodule

FILE: tb/fixed_point_affine_matrix_compose_unit_test.sv
// ----------------------------------------------------------------------------
// Affine compose unit testbench
// Loads first and second matrix rows into the compose unit, predicts every
// composed row in 4.12 fixed point and checks the output stream against it,
// with random gaps and stalls on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module fixed_point_affine_matrix_compose_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import famc_pkg::*;

  // One input word: a row of the first or second matrix.
  typedef struct packed {
    logic     op;
    row_idx_t row;
    elem_t    a;
    elem_t    b;
    elem_t    c;
    word_t    shift;
  } row_word_t;

  // One output word: a row of the composed transform.
  typedef struct packed {
    row_idx_t row;
    elem_t    a;
    elem_t    b;
    elem_t    c;
    word_t    shift;
    logic     last;
  } result_row_t;

  typedef enum logic {
    StepLoad,
    StepMode
  } step_kind_e;

  // One line of the directed plan. A load line may carry a typed-in result
  // that holds for all three composed rows; a mode line only uses the mode.
  typedef struct packed {
    step_kind_e kind;
    logic       mode;
    logic       op;
    row_idx_t   row;
    elem_t      a;
    elem_t      b;
    elem_t      c;
    word_t      shift;
    logic       pinned;
    elem_t      pa;
    elem_t      pb;
    elem_t      pc;
    word_t      pshift;
  } plan_step_t;

  localparam row_idx_t MidRow = 2'd1;
  localparam row_idx_t BadRow = 2'd3;

  localparam elem_t EMin = 16'sh8000;
  localparam elem_t EMax = 16'sh7fff;
  localparam elem_t EOne = 16'sh1000;
  localparam word_t WMin = 32'sh80000000;
  localparam word_t WMax = 32'sh7fffffff;

  localparam int DrainCycles   = 20;
  localparam int TailCycles    = 30;
  localparam int HoldCycles    = 150;
  localparam int RandPhases    = 8;
  localparam int LoadsPerPhase = 54;
  localparam int QuietPhase    = 3;
  localparam int CycleLimit    = 200000;

  // The directed plan. Zero matrices right after reset, the most negative
  // elements and translations, loads to row index three that must change
  // nothing, an early trigger that reuses stored rows, an identity first
  // matrix, and pass mode with the largest second translation.
  localparam plan_step_t DirectedPlan [27] = '{
    '{StepLoad, ModeCompose, OpFirst,  FirstRow, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  MidRow,   0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  LastRow,  0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, FirstRow, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, MidRow,   0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, LastRow,  0, 0, 0, 0, 1'b1, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  FirstRow, EMin, EMin, EMin, WMin, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  MidRow,   EMin, EMin, EMin, WMin, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  LastRow,  EMin, EMin, EMin, WMin, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, FirstRow, EMin, EMin, EMin, WMin, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, MidRow,   EMin, EMin, EMin, WMin, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, LastRow,  EMin, EMin, EMin, WMin, 1'b1, 0, 0, 0, WMin},
    '{StepLoad, ModeCompose, OpFirst,  BadRow, 16'sh1234, 16'sh5678, -16'sd1, 32'sh12345678,
      1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, BadRow,   EMax, EMax, EMax, WMax, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, LastRow,  EMin, EMin, EMin, WMin, 1'b1, 0, 0, 0, WMin},
    '{StepLoad, ModeCompose, OpFirst,  FirstRow, EOne, 0, 0, 100, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  MidRow,   0, EOne, 0, -200, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpFirst,  LastRow,  0, 0, EOne, WMax, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModeCompose, OpSecond, LastRow,  -16'sd1, 16'sd2, -16'sd3, -1, 1'b0, 0, 0, 0, 0},
    '{StepMode, ModePass,    OpFirst,  FirstRow, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpFirst,  FirstRow, 0, 0, 0, 5, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpFirst,  MidRow,   0, 0, 0, 6, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpFirst,  LastRow,  0, 0, 0, 7, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpSecond, FirstRow, EMax, EMax, EMax, WMax, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpSecond, MidRow,   EMax, EMax, EMax, WMax, 1'b0, 0, 0, 0, 0},
    '{StepLoad, ModePass,    OpSecond, LastRow,  EMax, EMax, EMax, WMax, 1'b1, 0, 0, 0, WMax},
    '{StepMode, ModeCompose, OpFirst,  FirstRow, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0}
  };

  // Clock, reset and the signals of the three channels.
  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;
  logic     in_valid;
  logic     in_stall;
  logic     operation;
  row_idx_t row;
  elem_t    elem_a;
  elem_t    elem_b;
  elem_t    elem_c;
  word_t    shift_term;
  logic     out_valid;
  logic     out_stall = 1'b0;
  row_idx_t out_row;
  elem_t    out_a;
  elem_t    out_b;
  elem_t    out_c;
  word_t    out_shift;
  logic     out_last;

  // Test control. These are changed with nonblocking assignments at the
  // falling edge so that the stall generator always sees a settled value.
  logic gaps_on     = 1'b1;
  logic pressure_go = 1'b0;
  logic out_hold    = 1'b0;

  // Predictor state: our own copy of both matrices and of the mode register.
  elem_t first_rot  [3][3];
  word_t first_off  [3];
  elem_t second_rot [3][3];
  word_t second_off [3];
  logic  mode_copy = ModeCompose;

  result_row_t expected_rows [$];
  int          mismatches = 0;
  int          loads_sent = 0;
  int          cycles     = 0;

  always #4 clk = ~clk;

  fixed_point_affine_matrix_compose_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .row_i        (row),
    .elem_a_i     (elem_a),
    .elem_b_i     (elem_b),
    .elem_c_i     (elem_c),
    .shift_term_i (shift_term),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_row_o    (out_row),
    .out_a_o      (out_a),
    .out_b_o      (out_b),
    .out_c_o      (out_c),
    .out_shift_o  (out_shift),
    .last_o       (out_last)
  );

  // One row of the composed transform. Every product and sum wraps at 32
  // bits; the fraction is dropped by an arithmetic shift, and the rotation
  // elements are then cut down to 16 bits.
  function automatic result_row_t compose_row(input int r);
    result_row_t res;
    word_t       acc;
    elem_t       col [3];
    int          c;
    int          k;
    for (c = 0; c < 3; c++) begin
      acc = '0;
      for (k = 0; k < 3; k++) begin
        acc = acc + word_t'(first_rot[r][k]) * word_t'(second_rot[k][c]);
      end
      col[c] = elem_t'(acc >>> FracBits);
    end
    res.row = row_idx_t'(r);
    res.a   = col[0];
    res.b   = col[1];
    res.c   = col[2];
    if (mode_copy == ModeCompose) begin
      acc = '0;
      for (k = 0; k < 3; k++) begin
        acc = acc + word_t'(first_rot[r][k]) * second_off[k];
      end
      res.shift = first_off[r] + (acc >>> FracBits);
    end else begin
      res.shift = second_off[r];
    end
    res.last = (r == 2);
    return res;
  endfunction

  // Stores an accepted row in the matrix copy. Row index three is dropped.
  // Row 2 of the second matrix queues the three composed rows, taken from the
  // typed-in values when the plan gives them.
  task automatic record_load(input row_word_t w, input logic pinned, input result_row_t pin);
    result_row_t res;
    int          r;
    if (w.row == BadRow) return;
    if (w.op == OpFirst) begin
      first_rot[w.row][0] = w.a;
      first_rot[w.row][1] = w.b;
      first_rot[w.row][2] = w.c;
      first_off[w.row]    = w.shift;
    end else begin
      second_rot[w.row][0] = w.a;
      second_rot[w.row][1] = w.b;
      second_rot[w.row][2] = w.c;
      second_off[w.row]    = w.shift;
    end
    if (w.op == OpSecond && w.row == LastRow) begin
      for (r = 0; r < 3; r++) begin
        if (pinned) begin
          res      = pin;
          res.row  = row_idx_t'(r);
          res.last = (r == 2);
        end else begin
          res = compose_row(r);
        end
        expected_rows.push_back(res);
      end
    end
  endtask

  // Random elements lean toward the extremes, the unit value and zero.
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 7))
      0: return EMin;
      1: return EMax;
      2: return '0;
      3: return -16'sd1;
      4: return EOne;
      5: return -EOne;
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic word_t rand_shift();
    case ($urandom_range(0, 6))
      0: return WMin;
      1: return WMax;
      2: return '0;
      3: return -32'sd1;
      4: return word_t'($urandom_range(0, 65535));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic row_word_t rand_word(input logic op, input row_idx_t r);
    row_word_t w;
    w.op    = op;
    w.row   = r;
    w.a     = rand_elem();
    w.b     = rand_elem();
    w.c     = rand_elem();
    w.shift = rand_shift();
    return w;
  endfunction

  // Offers one word, called and returning at a falling edge. Valid stays high
  // when the next word follows right away, so it is never dropped and raised
  // again in one step. The prediction is made at the accepting edge.
  task automatic push_row(input row_word_t w, input logic pinned, input result_row_t pin);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= w.op;
    row        <= w.row;
    elem_a     <= w.a;
    elem_b     <= w.b;
    elem_c     <= w.c;
    shift_term <= w.shift;
    do @(posedge clk); while (in_stall);
    record_load(w, pinned, pin);
    if (w.row != BadRow) loads_sent++;
    @(negedge clk);
  endtask

  // Writes the mode register once the unit has gone quiet: every queued row
  // has come out, then a further drain wait covers a row load still in flight.
  task automatic write_mode(input logic m);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_copy = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output stall: random stalls while gaps are on, and a solid stall while
  // the hold-off runs.
  always @(negedge clk) begin
    out_stall <= out_hold || (gaps_on && $urandom_range(0, 99) < 29);
  end

  // The long hold-off counts its own cycles. The sender keeps offering words
  // meanwhile, so the unit fills up and stalls its input.
  initial begin
    wait (pressure_go);
    @(negedge clk);
    out_hold <= 1'b1;
    repeat (HoldCycles) @(negedge clk);
    out_hold <= 1'b0;
  end

  // Each accepted output word is compared with the oldest expected row.
  always @(posedge clk) begin
    result_row_t got;
    result_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.row   = out_row;
      got.a     = out_a;
      got.b     = out_b;
      got.c     = out_c;
      got.shift = out_shift;
      got.last  = out_last;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: row %0d a %0d b %0d c %0d shift %0d last %0b",
                   got.row, got.a, got.b, got.c, got.shift, got.last);
        end
      end else begin
        want = expected_rows.pop_front();
        if (!(got.row === want.row && got.a === want.a && got.b === want.b &&
              got.c === want.c && got.shift === want.shift && got.last === want.last)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected row %0d a %0d b %0d c %0d shift %0d last %0b",
                     want.row, want.a, want.b, want.c, want.shift, want.last);
            $display("                 actual   row %0d a %0d b %0d c %0d shift %0d last %0b",
                     got.row, got.a, got.b, got.c, got.shift, got.last);
          end
        end
      end
    end
  end

  // A run that hangs ends here.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus: reset, the directed plan, then random phases that alternate
  // the mode. Most random words form whole matrix loads ending in a trigger;
  // the rest are partial reloads that trigger early and plain noise,
  // including loads to row index three.
  initial begin
    plan_step_t  s;
    row_word_t   w;
    result_row_t pin;
    result_row_t no_pin;
    int          order [5];
    int          p;
    int          i;
    int          j;
    int          n;
    int          tmp;
    int          kind;
    int          phase_end;
    logic        op;
    row_idx_t    r;

    no_pin     = '0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = ModeCompose;
    in_valid   = 1'b0;
    operation  = OpFirst;
    row        = FirstRow;
    elem_a     = '0;
    elem_b     = '0;
    elem_c     = '0;
    shift_term = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Both matrices are fully loaded by the first six lines, so no compose
    // ever reads a row that was never written.
    for (i = 0; i < 27; i++) begin
      s = DirectedPlan[i];
      if (s.kind == StepMode) begin
        write_mode(s.mode);
      end else begin
        w.op      = s.op;
        w.row     = s.row;
        w.a       = s.a;
        w.b       = s.b;
        w.c       = s.c;
        w.shift   = s.shift;
        pin.row   = FirstRow;
        pin.a     = s.pa;
        pin.b     = s.pb;
        pin.c     = s.pc;
        pin.shift = s.pshift;
        pin.last  = 1'b0;
        push_row(w, s.pinned, pin);
      end
    end

    for (p = 0; p < RandPhases; p++) begin
      if (p > 0) write_mode((p % 2 == 1) ? ModePass : ModeCompose);
      gaps_on   <= (p != QuietPhase);
      phase_end = loads_sent + LoadsPerPhase;
      while (loads_sent < phase_end) begin
        if (p == 0 && loads_sent + 40 >= phase_end) pressure_go <= 1'b1;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          // A whole transform pair in shuffled row order, triggered last.
          for (i = 0; i < 5; i++) order[i] = i;
          for (i = 4; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (i = 0; i < 5; i++) begin
            op = (order[i] < 3) ? OpFirst : OpSecond;
            push_row(rand_word(op, row_idx_t'(order[i] % 3)), 1'b0, no_pin);
          end
          push_row(rand_word(OpSecond, LastRow), 1'b0, no_pin);
        end else if (kind < 85) begin
          // A few rows reloaded, then an early trigger.
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) begin
            op = logic'($urandom_range(0, 1));
            r  = row_idx_t'($urandom_range(0, 2));
            if (op == OpSecond && r == LastRow) r = FirstRow;
            push_row(rand_word(op, r), 1'b0, no_pin);
          end
          push_row(rand_word(OpSecond, LastRow), 1'b0, no_pin);
        end else begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) begin
            op = logic'($urandom_range(0, 1));
            r  = row_idx_t'($urandom_range(0, 3));
            push_row(rand_word(op, r), 1'b0, no_pin);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
